### hw/rtl/lvlm_pkg.sv
`timescale 1ns / 1ps

package lvlm_pkg;

  localparam int MAX_FRAME_DEF = 4096;
  localparam int SAMPLE_W      = 16;
  localparam int LEVEL_W       = 16;
  localparam int SQ_W          = 31;
  localparam int ROOT_W        = 32;
  localparam int ROOT_STEPS    = 16;

endpackage

### hw/rtl/lvlm_if.sv
`timescale 1ns / 1ps

interface lvlm_sample_if;
  import lvlm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface lvlm_level_if;
  import lvlm_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] amplitude;
  logic [LEVEL_W-1:0] peak_level;
  logic [LEVEL_W-1:0] rms_level;
  logic               frame_overflow;

  modport source (output valid, output amplitude, output peak_level, output rms_level,
                  output frame_overflow, input ready);
  modport sink   (input valid, input amplitude, input peak_level, input rms_level,
                  input frame_overflow, output ready);
endinterface

### hw/rtl/frame_peak_rms_level_meter_top.sv
// Frame peak / RMS level meter.
// in_chan carries signed 16-bit samples, each with frame_end marking the last
// sample of a frame. An item is taken on every edge with valid and ready high.
// out_chan carries one item per frame: amplitude, peak_level, rms_level (all
// unsigned Q1.15, 32768 = 1.0) and frame_overflow, set when the frame held
// more than MAX_FRAME samples; levels then cover the first MAX_FRAME samples.
// Throughput: one sample per cycle inside a frame. The front end squares and
// accumulates in a two-stage pipe and hands each finished frame to a two-entry
// queue. The back end divides bit-serially (SUM_W = 30 + clog2(MAX_FRAME+1),
// 43 by default), then takes the square root bit-serially, and holds the
// result until it is accepted; only then does it take the next frame from
// the queue. While the queue is full the input stalls only while a frame-end
// item waits to be pushed. A stalled receiver holds the result and, once the
// queue fills, stops the input. Reset clears the frame accumulators, the
// queue and the back end; no clearing pass is needed.
`timescale 1ns / 1ps

module frame_peak_rms_level_meter_top
  import lvlm_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lvlm_sample_if.sink   in_chan,
  lvlm_level_if.source  out_chan
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = 30 + $clog2(MAX_FRAME + 1);
  localparam int Q_W   = SUM_W + CNT_W + LEVEL_W + 1;

  logic           q_push;
  logic           q_ready;
  logic [Q_W-1:0] q_wdata;
  logic           q_pop;
  logic           q_valid;
  logic [Q_W-1:0] q_rdata;

  lvlm_front #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .Q_W       (Q_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_ready (q_ready)
  );

  lvlm_queue #(
    .Q_W (Q_W)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .wready (q_ready),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .rvalid (q_valid)
  );

  lvlm_back #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .Q_W       (Q_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("frame pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.rms_level <= out_chan.peak_level &&
                        out_chan.amplitude == out_chan.peak_level &&
                        out_chan.peak_level <= 16'd32768))
    else $error("level result inconsistent");
`endif

endmodule

### hw/rtl/lvlm_front.sv
`timescale 1ns / 1ps

module lvlm_front
  import lvlm_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1),
  parameter int SUM_W     = 30 + $clog2(MAX_FRAME + 1),
  parameter int Q_W       = SUM_W + CNT_W + LEVEL_W + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  lvlm_sample_if.sink    in_chan,
  output logic           q_push,
  output logic [Q_W-1:0] q_wdata,
  input  logic           q_ready
);

  logic                s1_valid_r;
  logic [SQ_W-1:0]     s1_sq_r;
  logic [LEVEL_W-1:0]  s1_mag_r;
  logic                s1_end_r;
  logic                s1_adv;

  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [CNT_W-1:0]    tally_r;
  logic [CNT_W-1:0]    tally_nxt;
  logic [LEVEL_W-1:0]  peak_r;
  logic [LEVEL_W-1:0]  peak_nxt;
  logic                ovf_r;
  logic                ovf_nxt;

  logic [LEVEL_W-1:0]  mag;
  logic [2*LEVEL_W-1:0] sq_full;

  // magnitude: the most negative code maps to full scale
  assign mag     = in_chan.sample[SAMPLE_W-1] ? (~in_chan.sample + 1'b1) : in_chan.sample;
  assign sq_full = mag * mag;

  assign s1_adv        = s1_valid_r && (!s1_end_r || q_ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      s1_sq_r  <= sq_full[SQ_W-1:0];
      s1_mag_r <= mag;
      s1_end_r <= in_chan.frame_end;
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    peak_nxt  = peak_r;
    ovf_nxt   = ovf_r;
    if (tally_r < CNT_W'(MAX_FRAME)) begin
      sum_nxt   = sum_r + SUM_W'(s1_sq_r);
      tally_nxt = tally_r + 1'b1;
      if (s1_mag_r > peak_r) begin
        peak_nxt = s1_mag_r;
      end
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign q_push  = s1_adv && s1_end_r;
  assign q_wdata = {sum_nxt, tally_nxt, peak_nxt, ovf_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      tally_r <= '0;
      peak_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_end_r) begin
        sum_r   <= '0;
        tally_r <= '0;
        peak_r  <= '0;
        ovf_r   <= 1'b0;
      end else begin
        sum_r   <= sum_nxt;
        tally_r <= tally_nxt;
        peak_r  <= peak_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

endmodule

### hw/rtl/lvlm_queue.sv
`timescale 1ns / 1ps

module lvlm_queue
  import lvlm_pkg::*;
#(
  parameter int Q_W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [Q_W-1:0] wdata,
  output logic           wready,
  input  logic           pop,
  output logic [Q_W-1:0] rdata,
  output logic           rvalid
);

  logic [Q_W-1:0] mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign wready = (count_r != 2'd2);
  assign rvalid = (count_r != 2'd0);
  assign rdata  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hw/rtl/lvlm_back.sv
`timescale 1ns / 1ps

module lvlm_back
  import lvlm_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1),
  parameter int SUM_W     = 30 + $clog2(MAX_FRAME + 1),
  parameter int Q_W       = SUM_W + CNT_W + LEVEL_W + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  logic [Q_W-1:0] q_rdata,
  output logic           q_pop,
  lvlm_level_if.source   out_chan
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam int STEP_W = $clog2(SUM_W);

  logic [1:0]         state_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   tally_r;
  logic [CNT_W-1:0]   rem_r;
  logic [SUM_W-1:0]   dq_r;
  logic [LEVEL_W-1:0] peak_r;
  logic               ovf_r;
  logic [ROOT_W-1:0]  v_r;
  logic [ROOT_W-1:0]  res_r;
  logic [ROOT_W-1:0]  bit_r;
  logic [LEVEL_W-1:0] rms_r;
  logic [LEVEL_W-1:0] amp_r;

  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_sub;
  logic               div_ge;
  logic [ROOT_W-1:0]  trial;
  logic               root_ge;
  logic [ROOT_W-1:0]  v_nxt;
  logic [ROOT_W-1:0]  res_nxt;
  logic [LEVEL_W-1:0] rms_nxt;

  logic [SUM_W-1:0]   q_sum;
  logic [CNT_W-1:0]   q_tally;
  logic [LEVEL_W-1:0] q_peak;
  logic               q_ovf;

  assign {q_sum, q_tally, q_peak, q_ovf} = q_rdata;

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  assign rem_sh  = {rem_r, dq_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, tally_r};
  assign div_ge  = (rem_sh >= {1'b0, tally_r});

  assign trial   = res_r + bit_r;
  assign root_ge = (v_r >= trial);
  assign v_nxt   = root_ge ? (v_r - trial) : v_r;
  assign res_nxt = root_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign rms_nxt = res_nxt[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            tally_r <= q_tally;
            peak_r  <= q_peak;
            ovf_r   <= q_ovf;
            dq_r    <= q_sum;
            rem_r   <= '0;
            step_r  <= STEP_W'(SUM_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          dq_r  <= {dq_r[SUM_W-2:0], div_ge};
          if (step_r == '0) begin
            v_r     <= ROOT_W'({dq_r[SQ_W-2:0], div_ge});
            res_r   <= '0;
            bit_r   <= ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
            step_r  <= STEP_W'(ROOT_STEPS - 1);
            state_r <= ST_SQRT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_SQRT: begin
          v_r   <= v_nxt;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (step_r == '0) begin
            rms_r   <= rms_nxt;
            amp_r   <= (peak_r >= rms_nxt) ? peak_r : rms_nxt;
            state_r <= ST_OUT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_OUT: begin
          if (out_chan.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid          = (state_r == ST_OUT);
  assign out_chan.amplitude      = amp_r;
  assign out_chan.peak_level     = peak_r;
  assign out_chan.rms_level      = rms_r;
  assign out_chan.frame_overflow = ovf_r;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lvlm_pkg::*;

  localparam logic [16:0] FULL_SCALE = 17'd32768;
  localparam int          SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } sample_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] amplitude;
    logic [LEVEL_W-1:0] peak_level;
    logic [LEVEL_W-1:0] rms_level;
    logic               frame_overflow;
  } level_item_t;

  logic clk;
  logic rst_n = 1'b0;

  lvlm_sample_if sample_ch ();
  lvlm_level_if  level_ch ();

  frame_peak_rms_level_meter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (sample_ch.sink),
    .out_chan (level_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sample_item_t pending_samples[$];
  level_item_t  expected_levels[$];
  int           mismatch_count = 0;

  // frame accumulators of the predictor
  bit [42:0] frame_squares = '0;
  bit [16:0] frame_peak    = '0;
  int        frame_count   = 0;
  bit        frame_refused = 1'b0;

  logic sample_taken = 1'b0;
  logic level_taken  = 1'b0;

  initial begin
    sample_ch.valid     = 1'b0;
    sample_ch.sample    = '0;
    sample_ch.frame_end = 1'b0;
    level_ch.ready      = 1'b0;
  end

  task automatic add_sample(input logic [SAMPLE_W-1:0] s, input logic fe);
    sample_item_t it;
    it.sample    = s;
    it.frame_end = fe;
    pending_samples.push_back(it);
  endtask

  task automatic predict_levels(input logic [SAMPLE_W-1:0] s, input logic fe);
    bit [16:0]   mag;
    bit [42:0]   mean_sq;
    bit [16:0]   root;
    bit [16:0]   trial;
    bit [16:0]   peak;
    level_item_t lv;
    mag = s[SAMPLE_W-1] ? 17'h10000 - {1'b0, s} : {1'b0, s};
    if (frame_count < MAX_FRAME_DEF) begin
      frame_squares += 43'(mag) * 43'(mag);
      if (mag > frame_peak) frame_peak = mag;
      frame_count++;
    end else begin
      frame_refused = 1'b1;
    end
    if (fe) begin
      mean_sq = (frame_count != 0) ? frame_squares / 43'(frame_count) : '0;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
        trial = root | (17'd1 << b);
        if (44'(trial) * 44'(trial) <= 44'(mean_sq)) root = trial;
      end
      if (root > FULL_SCALE) root = FULL_SCALE;
      peak = (frame_peak > FULL_SCALE) ? FULL_SCALE : frame_peak;
      lv.peak_level     = peak[LEVEL_W-1:0];
      lv.rms_level      = root[LEVEL_W-1:0];
      lv.amplitude      = (peak > root) ? peak[LEVEL_W-1:0] : root[LEVEL_W-1:0];
      lv.frame_overflow = frame_refused;
      expected_levels.push_back(lv);
      frame_squares = '0;
      frame_peak    = '0;
      frame_count   = 0;
      frame_refused = 1'b0;
    end
  endtask

  // sample driver
  int sample_wait  = 0;
  bit sample_burst = 1'b0;

  always @(negedge clk) begin
    sample_item_t it;
    if (!rst_n) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) sample_burst = !sample_burst;
      if (sample_ch.valid && !sample_taken) begin
        // hold until taken
      end else if (sample_wait > 0) begin
        sample_wait--;
        sample_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        it = pending_samples.pop_front();
        sample_ch.sample    <= it.sample;
        sample_ch.frame_end <= it.frame_end;
        sample_ch.valid     <= 1'b1;
        sample_wait = sample_burst ? 0 : $urandom_range(0, 3);
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  int level_hold  = 0;
  bit level_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      level_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) level_burst = !level_burst;
      if (level_taken) level_hold = level_burst ? 0 : $urandom_range(0, 3);
      if (level_hold > 0) begin
        level_hold--;
        level_ch.ready <= 1'b0;
      end else begin
        level_ch.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    level_item_t want;
    sample_taken <= rst_n && sample_ch.valid && sample_ch.ready;
    level_taken  <= rst_n && level_ch.valid && level_ch.ready;
    if (rst_n && sample_ch.valid && sample_ch.ready)
      predict_levels(sample_ch.sample, sample_ch.frame_end);
    if (rst_n && level_ch.valid && level_ch.ready) begin
      if (expected_levels.size() == 0) begin
        $error("level item with none expected");
        mismatch_count++;
      end else begin
        want = expected_levels.pop_front();
        if (level_ch.amplitude !== want.amplitude) begin
          $error("amplitude: expected %0d, got %0d", want.amplitude, level_ch.amplitude);
          mismatch_count++;
        end
        if (level_ch.peak_level !== want.peak_level) begin
          $error("peak_level: expected %0d, got %0d", want.peak_level,
                 level_ch.peak_level);
          mismatch_count++;
        end
        if (level_ch.rms_level !== want.rms_level) begin
          $error("rms_level: expected %0d, got %0d", want.rms_level, level_ch.rms_level);
          mismatch_count++;
        end
        if (level_ch.frame_overflow !== want.frame_overflow) begin
          $error("frame_overflow: expected %0d, got %0d", want.frame_overflow,
                 level_ch.frame_overflow);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int issued;
    int len;
    logic [SAMPLE_W-1:0] s;

    // single-sample frames at the extremes, then short multi-sample frames
    add_sample(16'h0000, 1'b1);
    add_sample(16'h8000, 1'b1);
    add_sample(16'h7fff, 1'b1);
    add_sample(16'hffff, 1'b1);
    add_sample(16'h0001, 1'b1);
    add_sample(16'h5555, 1'b0);
    add_sample(16'haaaa, 1'b1);
    add_sample(16'h7fff, 1'b0);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h0000, 1'b1);
    add_sample(16'h0001, 1'b0);
    add_sample(16'hffff, 1'b1);
    add_sample(16'd100, 1'b0);
    add_sample(-16'sd200, 1'b0);
    add_sample(16'd300, 1'b0);
    add_sample(-16'sd400, 1'b1);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b1);

    issued = 0;
    while (issued < 1530) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        8:       len = $urandom_range(17, 64);
        9:       len = $urandom_range(65, 300);
        default: len = $urandom_range(2, 16);
      endcase
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0:       s = 16'h8000;
          1:       s = 16'h7fff;
          2:       s = 16'($urandom_range(0, 64)) - 16'd32;
          3:       s = 16'h0000;
          default: s = 16'($urandom);
        endcase
        add_sample(s, i == len - 1);
      end
      issued += len;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_samples.size() != 0 || sample_ch.valid) @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
